@@ rtl/vt_pkg.sv @@
// shared constants, codes and types for the vertex transform block
`timescale 1ns / 1ps
`default_nettype none

package vt_pkg;

   // lanes carried by one transaction
   localparam int LANES = 4;

   // data word and full product widths
   localparam int WORD_W = 32;
   localparam int PROD_W = 2 * WORD_W;

   // defaults for the top level parameters
   localparam int DIM_DEFAULT       = 4;
   localparam int FRAC_BITS_DEFAULT = 16;

   // saturation limits
   localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

   // command codes
   typedef enum logic {
      CMD_LOAD      = 1'b0,
      CMD_TRANSFORM = 1'b1
   } command_type;

   // one column write into the matrix store
   typedef struct packed {
      logic                      enable;
      logic [1:0]                column;
      logic [LANES*WORD_W-1:0]   data;
   } col_write_type;

endpackage

`default_nettype wire

@@ rtl/vt_req_if.sv @@
// request channel: command, column index and four q16.16 lanes
`timescale 1ns / 1ps
`default_nettype none

interface vt_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [1:0]                  column_index;
   logic signed [vt_pkg::WORD_W-1:0] in_x;
   logic signed [vt_pkg::WORD_W-1:0] in_y;
   logic signed [vt_pkg::WORD_W-1:0] in_z;
   logic signed [vt_pkg::WORD_W-1:0] in_w;

   modport source (
      output valid, command, column_index, in_x, in_y, in_z, in_w,
      input  ready
   );

   modport sink (
      input  valid, command, column_index, in_x, in_y, in_z, in_w,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/vt_rsp_if.sv @@
// response channel: four saturated q16.16 lanes and the clip flag
`timescale 1ns / 1ps
`default_nettype none

interface vt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic signed [vt_pkg::WORD_W-1:0] out_x;
   logic signed [vt_pkg::WORD_W-1:0] out_y;
   logic signed [vt_pkg::WORD_W-1:0] out_z;
   logic signed [vt_pkg::WORD_W-1:0] out_w;
   logic                        saturated;

   modport source (
      output valid, out_x, out_y, out_z, out_w, saturated,
      input  ready
   );

   modport sink (
      input  valid, out_x, out_y, out_z, out_w, saturated,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/vt_matrix_store.sv @@
// matrix register file, written one column at a time
`timescale 1ns / 1ps
`default_nettype none

module vt_matrix_store #(
   parameter int DIM = vt_pkg::DIM_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire vt_pkg::col_write_type col_write,
   output logic [((DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES) *
                 ((DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES) *
                 vt_pkg::WORD_W - 1:0] matrix
);

   // the matrix holds at most four rows and columns, as DIM is capped at the lane count
   localparam int N_ACT = (DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES;
   localparam int W     = vt_pkg::WORD_W;

   logic [N_ACT*N_ACT*W-1:0] matrix_ff;
   logic [N_ACT*N_ACT*W-1:0] matrix_in;

   // column write, ignored for columns outside the matrix
   always_comb begin
      matrix_in = matrix_ff;
      if (col_write.enable && (int'(col_write.column) < N_ACT)) begin
         for (int r = 0; r < N_ACT; r++) begin
            for (int c = 0; c < N_ACT; c++) begin
               if (int'(col_write.column) == c) begin
                  matrix_in[(r*N_ACT + c)*W +: W] = col_write.data[r*W +: W];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= '0;
      end else begin
         matrix_ff <= matrix_in;
      end
   end

   assign matrix = matrix_ff;

endmodule

`default_nettype wire

@@ rtl/vt_multiply.sv @@
// stage one: all row by column products at full width
`timescale 1ns / 1ps
`default_nettype none

module vt_multiply #(
   parameter int DIM = vt_pkg::DIM_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire logic [vt_pkg::LANES*vt_pkg::WORD_W-1:0] vec,
   input  wire logic [((DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES) *
                      ((DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES) *
                      vt_pkg::WORD_W - 1:0] matrix,
   output logic      out_valid,
   input  wire logic out_ready,
   output logic [((DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES) *
                 ((DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES) *
                 vt_pkg::PROD_W - 1:0] products
);

   localparam int N_ACT = (DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES;
   localparam int W     = vt_pkg::WORD_W;
   localparam int PW    = vt_pkg::PROD_W;

   logic                      valid_ff;
   logic                      valid_in;
   logic [N_ACT*N_ACT*PW-1:0] prod_ff;
   logic [N_ACT*N_ACT*PW-1:0] prod_in;

   // stage advances when empty or when the next stage takes its contents
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // one signed multiplier per matrix entry
   always_comb begin
      logic signed [W-1:0]  a;
      logic signed [W-1:0]  b;
      logic signed [PW-1:0] p;
      prod_in = prod_ff;
      for (int r = 0; r < N_ACT; r++) begin
         for (int c = 0; c < N_ACT; c++) begin
            a = $signed(matrix[(r*N_ACT + c)*W +: W]);
            b = $signed(vec[c*W +: W]);
            p = a * b;
            if (in_ready) begin
               prod_in[(r*N_ACT + c)*PW +: PW] = p;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign out_valid = valid_ff;
   assign products  = prod_ff;

endmodule

`default_nettype wire

@@ rtl/vt_accumulate.sv @@
// stage two: exact sum of the products of each row
`timescale 1ns / 1ps
`default_nettype none

module vt_accumulate #(
   parameter int DIM = vt_pkg::DIM_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire logic [((DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES) *
                      ((DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES) *
                      vt_pkg::PROD_W - 1:0] products,
   output logic      out_valid,
   input  wire logic out_ready,
   output logic [((DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES) *
                 (vt_pkg::PROD_W + $clog2((DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES))
                 - 1:0] sums
);

   localparam int N_ACT = (DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES;
   localparam int PW    = vt_pkg::PROD_W;
   localparam int SW    = PW + $clog2(N_ACT);
   localparam int GROW  = SW - PW;

   logic                 valid_ff;
   logic                 valid_in;
   logic [N_ACT*SW-1:0]  sum_ff;
   logic [N_ACT*SW-1:0]  sum_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // sign-extended add over the columns of each row
   always_comb begin
      logic [PW-1:0] p;
      logic [SW-1:0] acc;
      sum_in = sum_ff;
      for (int r = 0; r < N_ACT; r++) begin
         acc = '0;
         for (int c = 0; c < N_ACT; c++) begin
            p   = products[(r*N_ACT + c)*PW +: PW];
            acc = acc + {{GROW{p[PW-1]}}, p};
         end
         if (in_ready) begin
            sum_in[r*SW +: SW] = acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign out_valid = valid_ff;
   assign sums      = sum_ff;

endmodule

`default_nettype wire

@@ rtl/vt_saturate.sv @@
// stage three: fraction shift, saturation and the response register
`timescale 1ns / 1ps
`default_nettype none

module vt_saturate #(
   parameter int DIM       = vt_pkg::DIM_DEFAULT,
   parameter int FRAC_BITS = vt_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic      in_ready,
   input  wire logic [((DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES) *
                      (vt_pkg::PROD_W + $clog2((DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES))
                      - 1:0] sums,
   vt_rsp_if.source  rsp
);

   localparam int N_ACT = (DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES;
   localparam int W     = vt_pkg::WORD_W;
   localparam int SW    = vt_pkg::PROD_W + $clog2(N_ACT);
   localparam int L     = vt_pkg::LANES;

   logic                valid_ff;
   logic                valid_in;
   logic [L*W-1:0]      out_ff;
   logic [L*W-1:0]      out_in;
   logic                clip_ff;
   logic                clip_in;

   assign in_ready = !valid_ff || rsp.ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // arithmetic shift, then clip where the upper bits are not all sign
   always_comb begin
      logic signed [SW-1:0] s;
      logic signed [SW-1:0] shifted;
      logic [SW-W:0]        upper;
      logic                 fits;
      logic [L*W-1:0]       lanes;
      logic                 any_clip;
      lanes    = '0;
      any_clip = 1'b0;
      for (int r = 0; r < N_ACT; r++) begin
         s       = $signed(sums[r*SW +: SW]);
         shifted = s >>> FRAC_BITS;
         upper   = shifted[SW-1:W-1];
         fits    = (&upper) || !(|upper);
         if (fits) begin
            lanes[r*W +: W] = shifted[W-1:0];
         end else begin
            lanes[r*W +: W] = s[SW-1] ? vt_pkg::WORD_MIN : vt_pkg::WORD_MAX;
            any_clip        = 1'b1;
         end
      end
      out_in  = in_ready ? lanes : out_ff;
      clip_in = in_ready ? any_clip : clip_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      clip_ff <= clip_in;
   end

   // response channel
   assign rsp.valid     = valid_ff;
   assign rsp.out_x     = $signed(out_ff[0*W +: W]);
   assign rsp.out_y     = $signed(out_ff[1*W +: W]);
   assign rsp.out_z     = $signed(out_ff[2*W +: W]);
   assign rsp.out_w     = $signed(out_ff[3*W +: W]);
   assign rsp.saturated = clip_ff;

endmodule

`default_nettype wire

@@ rtl/vertex_transform_4x4.sv @@
// top level of the streaming fixed-point matrix by vector transform
// a transform passes the multiply, add and clip registers before its response shows
// throughput: one transaction per cycle while responses are taken (three-stage pipeline)
// a column load gives no response and is seen by the next transform
// each stage holds its contents while the response side stalls and fills bubbles meanwhile
// reset empties the pipeline and clears every matrix entry to zero
`timescale 1ns / 1ps
`default_nettype none

module vertex_transform_4x4 #(
   parameter int DIM       = vt_pkg::DIM_DEFAULT,
   parameter int FRAC_BITS = vt_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   vt_req_if.sink    req_chan,
   vt_rsp_if.source  rsp_chan
);

   localparam int N_ACT = (DIM < vt_pkg::LANES) ? DIM : vt_pkg::LANES;
   localparam int W     = vt_pkg::WORD_W;
   localparam int PW    = vt_pkg::PROD_W;
   localparam int SW    = PW + $clog2(N_ACT);

   logic [vt_pkg::LANES*W-1:0] vec;
   vt_pkg::col_write_type      col_write;
   logic [N_ACT*N_ACT*W-1:0]   matrix;
   logic [N_ACT*N_ACT*PW-1:0]  products;
   logic [N_ACT*SW-1:0]        sums;
   logic                       s1_ready;
   logic                       s1_valid;
   logic                       s2_ready;
   logic                       s2_valid;
   logic                       s3_ready;
   logic                       xform_valid;

   // input lanes, x in the lowest word
   assign vec = {req_chan.in_w, req_chan.in_z, req_chan.in_y, req_chan.in_x};

   // split the request by command
   assign req_chan.ready   = s1_ready;
   assign xform_valid      = req_chan.valid &&
                             (req_chan.command == vt_pkg::CMD_TRANSFORM);
   assign col_write.enable = req_chan.valid && s1_ready &&
                             (req_chan.command == vt_pkg::CMD_LOAD);
   assign col_write.column = req_chan.column_index;
   assign col_write.data   = vec;

   vt_matrix_store #(
      .DIM (DIM)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .col_write (col_write),
      .matrix    (matrix)
   );

   vt_multiply #(
      .DIM (DIM)
   ) u_multiply (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xform_valid),
      .in_ready  (s1_ready),
      .vec       (vec),
      .matrix    (matrix),
      .out_valid (s1_valid),
      .out_ready (s2_ready),
      .products  (products)
   );

   vt_accumulate #(
      .DIM (DIM)
   ) u_accumulate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s2_ready),
      .products  (products),
      .out_valid (s2_valid),
      .out_ready (s3_ready),
      .sums      (sums)
   );

   vt_saturate #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_saturate (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_valid),
      .in_ready (s3_ready),
      .sums     (sums),
      .rsp      (rsp_chan)
   );

endmodule

`default_nettype wire

@@ tb/tb_vertex_transform_4x4.sv @@
// self-checking testbench for the streaming 4x4 fixed-point vertex transform
`timescale 1ns / 1ps

module tb_vertex_transform_4x4;

   localparam int WORD_W        = vt_pkg::WORD_W;
   localparam int PROD_W        = vt_pkg::PROD_W;
   localparam int LANES         = vt_pkg::LANES;
   localparam int FRAC_BITS     = vt_pkg::FRAC_BITS_DEFAULT;
   localparam int STALL_LIMIT   = 2000;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_ITEMS   = 334;
   localparam int LOAD_PCT      = 35;
   localparam int DRAIN_CYCLES  = 8;
   localparam int N_DIRECTED    = 21;

   localparam logic [WORD_W-1:0] WORD_MAX = vt_pkg::WORD_MAX;
   localparam logic [WORD_W-1:0] WORD_MIN = vt_pkg::WORD_MIN;
   localparam logic [WORD_W-1:0] ONE_Q    = 32'h0001_0000;
   localparam logic [WORD_W-1:0] NEG_ONE  = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] ZERO_W   = 32'h0000_0000;

   // one transformed vertex as it leaves the block
   typedef struct packed {
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
      logic [WORD_W-1:0] w;
      logic              saturated;
   } vertex_result_type;

   // one request transaction, with an optional hand-written expectation
   typedef struct packed {
      vt_pkg::command_type command;
      logic [1:0]          column;
      logic [WORD_W-1:0]   x;
      logic [WORD_W-1:0]   y;
      logic [WORD_W-1:0]   z;
      logic [WORD_W-1:0]   w;
      logic                typed;
      vertex_result_type   wanted;
   } stim_row_type;

   localparam vertex_result_type NO_CHECK = '0;

   logic clock;
   logic reset;

   vt_req_if req_chan ();
   vt_rsp_if rsp_chan ();

   vertex_transform_4x4 u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // matrix copy held by the predictor, column-major, unlike the row-major store in the block
   logic signed [WORD_W-1:0] model_matrix [LANES*LANES];
   vertex_result_type        expected_vertices [$];

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned mismatch_count;
   int unsigned quiet_cycles;

   // expectation attached to the transaction currently offered
   logic              row_typed;
   vertex_result_type row_wanted;

   // directed part: reset contents, identity, saturation both ways, rounding
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{vt_pkg::CMD_TRANSFORM, 2'd0, WORD_MAX, WORD_MIN, NEG_ONE, 32'h1, 1'b1,
        '{ZERO_W, ZERO_W, ZERO_W, ZERO_W, 1'b0}},
      '{vt_pkg::CMD_LOAD, 2'd0, ONE_Q, ZERO_W, ZERO_W, ZERO_W, 1'b0, NO_CHECK},
      '{vt_pkg::CMD_LOAD, 2'd1, ZERO_W, ONE_Q, ZERO_W, ZERO_W, 1'b0, NO_CHECK},
      '{vt_pkg::CMD_LOAD, 2'd2, ZERO_W, ZERO_W, ONE_Q, ZERO_W, 1'b0, NO_CHECK},
      '{vt_pkg::CMD_LOAD, 2'd3, ZERO_W, ZERO_W, ZERO_W, ONE_Q, 1'b0, NO_CHECK},
      '{vt_pkg::CMD_TRANSFORM, 2'd0, WORD_MAX, WORD_MIN, NEG_ONE, 32'h1, 1'b1,
        '{WORD_MAX, WORD_MIN, NEG_ONE, 32'h1, 1'b0}},
      '{vt_pkg::CMD_TRANSFORM, 2'd3, 32'h0000_8000, 32'hFFFF_8000,
        32'h1234_5678, 32'hEDCB_A988, 1'b0, NO_CHECK},
      '{vt_pkg::CMD_LOAD, 2'd0, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0, NO_CHECK},
      '{vt_pkg::CMD_TRANSFORM, 2'd1, WORD_MAX, ZERO_W, ZERO_W, ZERO_W, 1'b1,
        '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b1}},
      '{vt_pkg::CMD_TRANSFORM, 2'd2, WORD_MIN, ZERO_W, ZERO_W, ZERO_W, 1'b1,
        '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b1}},
      '{vt_pkg::CMD_LOAD, 2'd3, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b0, NO_CHECK},
      '{vt_pkg::CMD_TRANSFORM, 2'd0, ZERO_W, ZERO_W, ZERO_W, WORD_MIN, 1'b1,
        '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b1}},
      '{vt_pkg::CMD_TRANSFORM, 2'd0, 32'h1, ZERO_W, ZERO_W, 32'h1, 1'b0, NO_CHECK},
      '{vt_pkg::CMD_LOAD, 2'd1, 32'h1, NEG_ONE, ONE_Q, 32'h1234_5678, 1'b0, NO_CHECK},
      '{vt_pkg::CMD_TRANSFORM, 2'd0, 32'h1, 32'h1, 32'h1, 32'h1, 1'b0, NO_CHECK},
      '{vt_pkg::CMD_LOAD, 2'd2, 32'h0000_FFFF, 32'hFFFF_0001,
        32'h0002_0000, 32'hFFFE_0000, 1'b0, NO_CHECK},
      '{vt_pkg::CMD_TRANSFORM, 2'd0, 32'hAAAA_AAAA, 32'h5555_5555,
        32'hAAAA_AAAA, 32'h5555_5555, 1'b0, NO_CHECK},
      '{vt_pkg::CMD_LOAD, 2'd0, ZERO_W, ZERO_W, ZERO_W, ZERO_W, 1'b0, NO_CHECK},
      '{vt_pkg::CMD_LOAD, 2'd3, ZERO_W, ZERO_W, ZERO_W, ZERO_W, 1'b0, NO_CHECK},
      '{vt_pkg::CMD_TRANSFORM, 2'd0, NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE, 1'b0, NO_CHECK},
      '{vt_pkg::CMD_TRANSFORM, 2'd0, ONE_Q, WORD_MAX, WORD_MIN, 32'h7FFF_0000,
        1'b0, NO_CHECK}
   };

   // row dot products, exact sum, floor shift, clip to 32 bits
   function automatic vertex_result_type transform_vertex(
      input logic [WORD_W-1:0] vx, vy, vz, vw
   );
      logic signed [WORD_W-1:0]   vec [LANES];
      logic [WORD_W-1:0]          lane [LANES];
      logic signed [PROD_W-1:0]   prod;
      logic signed [PROD_W+1:0]   acc;
      logic signed [PROD_W+1:0]   scaled;
      vertex_result_type          res;
      vec[0] = vx;
      vec[1] = vy;
      vec[2] = vz;
      vec[3] = vw;
      res.saturated = 1'b0;
      for (int r = 0; r < LANES; r++) begin
         acc = '0;
         for (int c = 0; c < LANES; c++) begin
            prod = model_matrix[c*LANES + r] * vec[c];
            acc  = acc + prod;
         end
         scaled = acc >>> FRAC_BITS;
         if (scaled[PROD_W+1:WORD_W-1] == '0 || scaled[PROD_W+1:WORD_W-1] == '1) begin
            lane[r] = scaled[WORD_W-1:0];
         end else begin
            lane[r]       = scaled[PROD_W+1] ? WORD_MIN : WORD_MAX;
            res.saturated = 1'b1;
         end
      end
      res.x = lane[0];
      res.y = lane[1];
      res.z = lane[2];
      res.w = lane[3];
      return res;
   endfunction

   // random lane value: extremes, values within two units, within eight units, or anything
   function automatic logic [WORD_W-1:0] random_lane();
      case ($urandom_range(9))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2, 3, 4: return WORD_W'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
         5, 6:    return WORD_W'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
         default: return WORD_W'($urandom);
      endcase
   endfunction

   // offer one transaction and hold it until the block takes it
   task automatic send_transaction(input stim_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      row_typed              = row.typed;
      row_wanted             = row.wanted;
      req_chan.valid        <= 1'b1;
      req_chan.command      <= row.command;
      req_chan.column_index <= row.column;
      req_chan.in_x         <= row.x;
      req_chan.in_y         <= row.y;
      req_chan.in_z         <= row.z;
      req_chan.in_w         <= row.w;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // hold the sender off until every outstanding transform has come back
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (expected_vertices.size() != 0) @(negedge clock);
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // predictor, checker and watchdog, all on the rising edge
   always @(posedge clock) begin
      vertex_result_type got;
      vertex_result_type wanted;
      if (reset) begin
         quiet_cycles = 0;
         for (int i = 0; i < LANES*LANES; i++) model_matrix[i] = '0;
      end else begin
         // result transaction
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.out_x, rsp_chan.out_y, rsp_chan.out_z, rsp_chan.out_w,
                    rsp_chan.saturated};
            if (expected_vertices.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: result with nothing expected: x=%h y=%h z=%h w=%h sat=%b",
                           $realtime, got.x, got.y, got.z, got.w, got.saturated);
            end else begin
               wanted = expected_vertices.pop_front();
               if (got.x !== wanted.x || got.y !== wanted.y || got.z !== wanted.z ||
                   got.w !== wanted.w || got.saturated !== wanted.saturated) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"%0t: mismatch exp x=%h y=%h z=%h w=%h sat=%b, ",
                               "got x=%h y=%h z=%h w=%h sat=%b"},
                              $realtime, wanted.x, wanted.y, wanted.z, wanted.w,
                              wanted.saturated, got.x, got.y, got.z, got.w, got.saturated);
               end
            end
         end
         // request transaction
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.command == vt_pkg::CMD_LOAD) begin
               model_matrix[req_chan.column_index*LANES + 0] = req_chan.in_x;
               model_matrix[req_chan.column_index*LANES + 1] = req_chan.in_y;
               model_matrix[req_chan.column_index*LANES + 2] = req_chan.in_z;
               model_matrix[req_chan.column_index*LANES + 3] = req_chan.in_w;
            end else if (row_typed) begin
               expected_vertices.push_back(row_wanted);
            end else begin
               expected_vertices.push_back(transform_vertex(req_chan.in_x, req_chan.in_y,
                                                            req_chan.in_z, req_chan.in_w));
            end
         end
         // watchdog on cycles with no transaction on either side
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      stim_row_type row;
      mismatch_count        = 0;
      quiet_cycles          = 0;
      row_typed             = 1'b0;
      row_wanted            = NO_CHECK;
      send_idle_pct         = 6;
      recv_stall_pct        = 49;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.command      = vt_pkg::CMD_LOAD;
      req_chan.column_index = '0;
      req_chan.in_x         = '0;
      req_chan.in_y         = '0;
      req_chan.in_z         = '0;
      req_chan.in_w         = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (int i = 0; i < N_DIRECTED; i++) send_transaction(directed_rows[i]);
      wait_for_drain();

      // random phases: sender light / receiver heavy, swapped, then none
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 6;  recv_stall_pct = 49; end
            1:       begin send_idle_pct = 49; recv_stall_pct = 6;  end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            row.command = ($urandom_range(99) < LOAD_PCT) ? vt_pkg::CMD_LOAD
                                                          : vt_pkg::CMD_TRANSFORM;
            row.column  = 2'($urandom_range(3));
            row.x       = random_lane();
            row.y       = random_lane();
            row.z       = random_lane();
            row.w       = random_lane();
            row.typed   = 1'b0;
            row.wanted  = NO_CHECK;
            send_transaction(row);
         end
         wait_for_drain();
      end

      // let any stray transaction surface
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_vertices.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
